[sv/wos_pkg.sv]
// shared constants, types and helpers for the wheel odometer and speedometer
package wos_pkg;

   localparam int INTERVAL_BITS_DEFAULT = 12;
   localparam int SPEED_BITS = 16;
   localparam int CIRC_BITS = 8;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CIRCUMFERENCE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED = 1'b1;

   localparam logic [CIRC_BITS-1:0] CIRCUMFERENCE_RESET = 8'd88;
   localparam logic [SPEED_BITS-1:0] SPEED_RESET = 16'd5000;

   localparam logic [12:0] MILE_FEET = 13'd5280;
   localparam logic [12:0] EIGHTH_MILE = 13'd660;
   localparam logic [8:0] FOOT_INCHES = 9'd12;
   // 683 / 8192 is close enough to 1/12 for sums below 267
   localparam logic [9:0] RECIP_TWELVE = 10'd683;
   localparam int RECIP_SHIFT = 13;

   typedef struct packed {
      logic [3:0] inches;
      logic [12:0] feet;
      logic [15:0] miles;
      logic [7:0] leds;
   } odo_result_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // whole feet in a sum of inches (sum at most 266)
   function automatic logic [4:0] feet_from_inches(input logic [8:0] total);
      logic [18:0] prod;
      prod = total * RECIP_TWELVE;
      return prod[RECIP_SHIFT+4:RECIP_SHIFT];
   endfunction

endpackage

[sv/wos_odo.sv]
// odometer stores: inch carry, feet, miles and the eighth-mile bar
module wos_odo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              update,
   input  logic [wos_pkg::CIRC_BITS-1:0]     circumference,
   output wos_pkg::odo_result_type           result
);
   import wos_pkg::*;

   logic [3:0]  inch_ff, inch_in;
   logic [12:0] feet_ff, feet_in;
   logic [15:0] mile_ff, mile_in;
   logic [12:0] bar_ff, bar_in;
   logic [7:0]  leds_ff, leds_in;

   logic [8:0]  total;
   logic [4:0]  new_feet;
   logic [8:0]  used_inches;
   logic [12:0] feet_sum;
   logic [12:0] bar_sum;
   logic        bar_over;

   always_comb begin
      total = {5'd0, inch_ff} + {1'b0, circumference};
      new_feet = feet_from_inches(total);
      used_inches = total - 9'(new_feet * FOOT_INCHES);
      inch_in = used_inches[3:0];
      feet_sum = feet_ff + {8'd0, new_feet};
      if (feet_sum >= MILE_FEET) begin
         feet_in = feet_sum - MILE_FEET;
         mile_in = mile_ff + 16'd1;
      end else begin
         feet_in = feet_sum;
         mile_in = mile_ff;
      end
      bar_sum = bar_ff + {8'd0, new_feet};
      bar_over = bar_sum > MILE_FEET;
      bar_in = bar_over ? 13'd0 : bar_sum;
      // one led per eighth mile, filling from the top bit
      for (int j = 0; j < 8; j++) begin
         leds_in[7-j] = !bar_over && (bar_sum > 13'(j * EIGHTH_MILE));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inch_ff <= '0;
         feet_ff <= '0;
         mile_ff <= '0;
         bar_ff <= '0;
         leds_ff <= '0;
      end else if (update) begin
         inch_ff <= inch_in;
         feet_ff <= feet_in;
         mile_ff <= mile_in;
         bar_ff <= bar_in;
         leds_ff <= leds_in;
      end
   end

   assign result.inches = inch_ff;
   assign result.feet = feet_ff;
   assign result.miles = mile_ff;
   assign result.leds = leds_ff;

   a_feet_in_mile: assert property (@(posedge clock) disable iff (reset)
      feet_ff < MILE_FEET)
      else $error("foot count reached a full mile");

   a_bar_dark_when_empty: assert property (@(posedge clock) disable iff (reset)
      update && (bar_in == 13'd0) |=> leds_ff == 8'd0)
      else $error("bar lit with no feet counted");

endmodule

[sv/wos_div.sv]
// restoring serial divider, one quotient bit per cycle, saturated to 8 bits
module wos_div #(
   parameter int INTERVAL_BITS = wos_pkg::INTERVAL_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [wos_pkg::SPEED_BITS-1:0]    dividend,
   input  logic [INTERVAL_BITS-1:0]          divisor,
   output wos_pkg::div_status_type           status,
   output logic [7:0]                        quotient
);
   import wos_pkg::*;

   localparam int STEP_BITS = $clog2(SPEED_BITS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SPEED_BITS - 1);

   logic [INTERVAL_BITS-1:0] rem_ff, rem_in;
   logic [SPEED_BITS-1:0]    quo_ff, quo_in;
   logic [INTERVAL_BITS-1:0] divisor_ff;
   logic [STEP_BITS-1:0]     step_ff;
   logic                     busy_ff, done_ff;

   logic [INTERVAL_BITS:0]   trial;
   logic [INTERVAL_BITS:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[SPEED_BITS-1]};
      diff = trial - {1'b0, divisor_ff};
      // no borrow means the divisor fits: keep the difference
      if (!diff[INTERVAL_BITS]) begin
         rem_in = diff[INTERVAL_BITS-1:0];
         quo_in = {quo_ff[SPEED_BITS-2:0], 1'b1};
      end else begin
         rem_in = trial[INTERVAL_BITS-1:0];
         quo_in = {quo_ff[SPEED_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   // zero divisor gives all ones, which saturates as well
   assign quotient = (|quo_ff[SPEED_BITS-1:8]) ? 8'hFF : quo_ff[7:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[sv/wheel_odometer_speedometer.sv]
// top level: wheel pulse odometer and speedometer with csr port
//
//   channel | ports                      | direction | carries
//   req     | req_valid/ready            | in        | interval_ticks per pulse
//   rsp     | rsp_valid/ready            | out       | inches, feet, miles, bar, mph
//   csr     | csr_we/index/wdata         | in        | circumference, speed constant
//
// a pulse runs through the 16 steps of the serial divider (one quotient
// bit each), then the output load; the next transfer is taken only once
// the block is back in idle, so one pulse is divided at a time.
// the odometer update is done in the transfer cycle itself.
// reset is synchronous and restores the csr defaults and clears all counts.
// a result waiting on rsp_ready does not block the next pulse; a finished
// divide holds until the output register is free.
module wheel_odometer_speedometer #(
   parameter int INTERVAL_BITS = wos_pkg::INTERVAL_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [INTERVAL_BITS-1:0]            req_interval_ticks,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [3:0]                          rsp_inches_left,
   output logic [12:0]                         rsp_feet_count,
   output logic [15:0]                         rsp_mile_count,
   output logic [7:0]                          rsp_led_bar,
   output logic [7:0]                          rsp_speed_mph,
   input  logic                                csr_we,
   input  logic [wos_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wos_pkg::SPEED_BITS-1:0]      csr_wdata
);
   import wos_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CIRC_BITS-1:0]  circ_ff;
   logic [SPEED_BITS-1:0] speed_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   odo_result_type        out_odo_ff;
   logic [7:0]            out_mph_ff;

   logic                  accept;
   logic                  out_free;
   logic                  load;
   odo_result_type        odo_result;
   div_status_type        div_status;
   logic [7:0]            div_quotient;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   wos_odo u_odo (
      .clock         (clock),
      .reset         (reset),
      .update        (accept),
      .circumference (circ_ff),
      .result        (odo_result)
   );

   wos_div #(
      .INTERVAL_BITS (INTERVAL_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (speed_ff),
      .divisor  (req_interval_ticks),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in = state_ff;
      load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_DIV;
         end
         S_DIV: begin
            if (div_status.done) begin
               if (out_free) begin
                  load = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            if (out_free) begin
               load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_odo_ff <= odo_result;
         out_mph_ff <= div_quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff <= CIRCUMFERENCE_RESET;
         speed_ff <= SPEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CIRCUMFERENCE: circ_ff <= csr_wdata[CIRC_BITS-1:0];
            CSR_SPEED:         speed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_inches_left = out_odo_ff.inches;
   assign rsp_feet_count = out_odo_ff.feet;
   assign rsp_mile_count = out_odo_ff.miles;
   assign rsp_led_bar = out_odo_ff.leds;
   assign rsp_speed_mph = out_mph_ff;

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_DIV) && div_status.busy)
      else $error("transfer did not start the divider");

   a_divide_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   a_hold_means_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> rsp_valid_ff && !div_status.busy)
      else $error("holding a result with the output register free");

endmodule

[sim/testbench.sv]
// self-checking testbench for the wheel odometer and speedometer
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wos_pkg::*;

   localparam int TICK_BITS = INTERVAL_BITS_DEFAULT;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_COUNT = 6;
   localparam int PULSES_PER_PHASE = 288;

   typedef struct packed {
      logic [3:0]  inches;
      logic [12:0] feet;
      logic [15:0] miles;
      logic [7:0]  leds;
      logic [7:0]  mph;
   } odo_reading_type;

   typedef struct {
      bit                   set_circ;
      logic [15:0]          circ_word;
      bit                   set_speed;
      logic [15:0]          speed_word;
      logic [TICK_BITS-1:0] ticks;
      bit                   fixed;
      odo_reading_type      want;
   } pulse_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [TICK_BITS-1:0]          req_interval_ticks = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [3:0]                    rsp_inches_left;
   logic [12:0]                   rsp_feet_count;
   logic [15:0]                   rsp_mile_count;
   logic [7:0]                    rsp_led_bar;
   logic [7:0]                    rsp_speed_mph;
   logic                          csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = CSR_CIRCUMFERENCE;
   logic [SPEED_BITS-1:0]         csr_wdata = '0;

   wheel_odometer_speedometer #(.INTERVAL_BITS(TICK_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_interval_ticks(req_interval_ticks),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_inches_left(rsp_inches_left),
      .rsp_feet_count(rsp_feet_count),
      .rsp_mile_count(rsp_mile_count),
      .rsp_led_bar(rsp_led_bar),
      .rsp_speed_mph(rsp_speed_mph),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor copy of the registers and the distance counters
   logic [CIRC_BITS-1:0]  circ_reg = CIRCUMFERENCE_RESET;
   logic [SPEED_BITS-1:0] speed_reg = SPEED_RESET;
   logic [3:0]            inch_acc = '0;
   logic [12:0]           foot_acc = '0;
   logic [15:0]           mile_acc = '0;
   logic [12:0]           bar_acc = '0;

   odo_reading_type reading_q[$];
   pulse_row_type   directed_rows[$];
   int              mismatches = 0;
   int              readings_checked = 0;
   int              pulses_sent = 0;
   int              settings_used = 1;
   int              idle_cycles = 0;
   bit              hold_off_req = 1'b0;
   bit              hold_off_done = 1'b0;

   function automatic odo_reading_type advance_odometer(logic [TICK_BITS-1:0] ticks);
      logic [8:0]      total;
      logic [4:0]      new_feet;
      logic [12:0]     feet_sum;
      logic [3:0]      level;
      logic [15:0]     quotient;
      odo_reading_type r;
      total = 9'(inch_acc) + 9'(circ_reg);
      new_feet = 5'(total / FOOT_INCHES);
      inch_acc = 4'(total % FOOT_INCHES);
      feet_sum = foot_acc + 13'(new_feet);
      bar_acc = bar_acc + 13'(new_feet);
      if (feet_sum >= MILE_FEET) begin
         mile_acc = mile_acc + 16'd1;
         feet_sum = feet_sum - MILE_FEET;
      end
      foot_acc = feet_sum;
      r.inches = inch_acc;
      r.feet = foot_acc;
      r.miles = mile_acc;
      if (bar_acc == '0) begin
         r.leds = 8'h00;
      end else if (bar_acc > MILE_FEET) begin
         // past a full mile the bar goes dark and drops the surplus feet
         bar_acc = '0;
         r.leds = 8'h00;
      end else begin
         level = 4'((bar_acc - 13'd1) / EIGHTH_MILE + 13'd1);
         r.leds = 8'hFF << (4'd8 - level);
      end
      if (ticks == '0) begin
         r.mph = 8'd255;
      end else begin
         quotient = speed_reg / 16'(ticks);
         r.mph = (quotient > 16'd255) ? 8'd255 : quotient[7:0];
      end
      return r;
   endfunction

   function automatic pulse_row_type make_row(bit sc, logic [15:0] cw, bit ss, logic [15:0] sw,
                                              logic [TICK_BITS-1:0] t);
      pulse_row_type row;
      row.set_circ = sc;
      row.circ_word = cw;
      row.set_speed = ss;
      row.speed_word = sw;
      row.ticks = t;
      row.fixed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   // a mix of zero, the field extremes, small values, the saturation edge and uniform picks
   function automatic logic [TICK_BITS-1:0] pick_ticks();
      int sel;
      int edge_ticks;
      sel = $urandom_range(0, 7);
      case (sel) inside
         0: return '0;
         1: return {TICK_BITS{1'b1}};
         2: return TICK_BITS'($urandom_range(1, 31));
         3, 4: begin
            edge_ticks = int'(speed_reg >> 8) + int'($urandom_range(0, 4)) - 2;
            if (edge_ticks < 0) edge_ticks = 0;
            return TICK_BITS'(edge_ticks);
         end
         default: return TICK_BITS'($urandom_range(0, (1 << TICK_BITS) - 1));
      endcase
   endfunction

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [SPEED_BITS-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_CIRCUMFERENCE) circ_reg = data[CIRC_BITS-1:0];
      else speed_reg = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic idle_req(int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_interval_ticks <= TICK_BITS'($urandom_range(0, (1 << TICK_BITS) - 1));
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send_pulse(logic [TICK_BITS-1:0] ticks, bit fixed, odo_reading_type want);
      odo_reading_type predicted;
      @(negedge clock);
      req_valid <= 1'b1;
      req_interval_ticks <= ticks;
      do @(posedge clock); while (!req_ready);
      predicted = advance_odometer(ticks);
      reading_q.push_back(fixed ? want : predicted);
      pulses_sent++;
   endtask

   // registers change only with nothing in flight
   task automatic quiesce();
      idle_req(1);
      while (reading_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      odo_reading_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reading_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: in=%0d ft=%0d mi=%0d bar=%h mph=%0d",
                        rsp_inches_left, rsp_feet_count, rsp_mile_count, rsp_led_bar,
                        rsp_speed_mph);
         end else begin
            w = reading_q.pop_front();
            readings_checked++;
            if (rsp_inches_left !== w.inches || rsp_feet_count !== w.feet ||
                rsp_mile_count !== w.miles || rsp_led_bar !== w.leds ||
                rsp_speed_mph !== w.mph) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch #%0d: exp in=%0d ft=%0d mi=%0d bar=%h mph=%0d",
                           readings_checked, w.inches, w.feet, w.miles, w.leds, w.mph);
                  $display("   got in=%0d ft=%0d mi=%0d bar=%h mph=%0d",
                           rsp_inches_left, rsp_feet_count, rsp_mile_count, rsp_led_bar,
                           rsp_speed_mph);
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // receiver: segments of differing stall patterns, plus one long hold-off
   initial begin
      int mode;
      int seg_len;
      int beat;
      beat = 0;
      wait (!reset);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            seg_len = $urandom_range(4, 64);
            repeat (seg_len) begin
               @(negedge clock);
               beat++;
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= $urandom_range(0, 1);
                  2: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= (beat % 3 != 0);
               endcase
            end
         end
      end
   end

   // sender
   initial begin
      pulse_row_type row;
      int burst_left;
      int gap;
      logic [15:0] circ_word;
      logic [15:0] speed_word;
      odo_reading_type none;
      none = '0;

      // after reset: 88 in per pulse, 5000 speed constant
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd0));
      directed_rows[0].fixed = 1'b1;
      directed_rows[0].want = '{inches: 4'd4, feet: 13'd7, miles: 16'd0, leds: 8'h80,
                                mph: 8'd255};
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd4095));
      directed_rows[1].fixed = 1'b1;
      directed_rows[1].want = '{inches: 4'd8, feet: 13'd14, miles: 16'd0, leds: 8'h80,
                                mph: 8'd1};
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd1));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd19));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd20));
      // saturation edge with the largest constant
      directed_rows.push_back(make_row(0, 0, 1, 16'hFFFF, 12'd257));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd256));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd255));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd4095));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'hAAA));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'h555));
      directed_rows.push_back(make_row(0, 0, 1, 16'd0, 12'd1));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd0));
      // zero circumference leaves the counts alone
      directed_rows.push_back(make_row(1, 16'd0, 1, 16'd5000, 12'd100));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd2048));
      // upper byte of the write word must be dropped
      directed_rows.push_back(make_row(1, 16'hA5FF, 0, 0, 12'd7));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd3000));
      directed_rows.push_back(make_row(1, 16'd1, 0, 0, 12'd4094));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd1));
      directed_rows.push_back(make_row(1, 16'd240, 1, 16'd1, 12'd1));
      directed_rows.push_back(make_row(0, 0, 0, 0, 12'd2));
      directed_rows.push_back(make_row(0, 0, 1, 16'd255, 12'd1));
      directed_rows.push_back(make_row(0, 0, 1, 16'd256, 12'd1));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.set_circ || row.set_speed) begin
            quiesce();
            if (row.set_circ) write_reg(CSR_CIRCUMFERENCE, row.circ_word);
            if (row.set_speed) write_reg(CSR_SPEED, row.speed_word);
            settings_used++;
         end
         send_pulse(row.ticks, row.fixed, row.want);
         idle_req($urandom_range(0, 3));
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin circ_word = 16'h00FF; speed_word = 16'hFFFF; end
            1: begin circ_word = 16'h0001; speed_word = 16'h0001; end
            2: begin
               circ_word = {8'($urandom), 8'($urandom_range(200, 255))};
               speed_word = 16'($urandom);
            end
            3: begin circ_word = 16'h0000; speed_word = 16'h0000; end
            4: begin circ_word = 16'($urandom); speed_word = 16'($urandom); end
            default: begin circ_word = 16'd240; speed_word = 16'd5000; end
         endcase
         quiesce();
         write_reg(CSR_CIRCUMFERENCE, circ_word);
         write_reg(CSR_SPEED, speed_word);
         settings_used++;
         burst_left = 0;
         for (int n = 0; n < PULSES_PER_PHASE; n++) begin
            if (phase == 1 && n == 50) hold_off_req = 1'b1;
            send_pulse(pick_ticks(), 1'b0, none);
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               // last phase runs back to back
               gap = (phase == PHASE_COUNT - 1 || $urandom_range(0, 3) == 0) ?
                     0 : $urandom_range(1, 25);
               idle_req(gap);
            end else begin
               burst_left--;
            end
         end
      end

      idle_req(1);
      while (reading_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d wheel pulses under %0d register settings, %0d results checked",
               pulses_sent, settings_used, readings_checked);
      $display("distance reached %0d miles %0d feet, %0d mismatches",
               mile_acc, foot_acc, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
sv/wos_pkg.sv
sv/wos_odo.sv
sv/wos_div.sv
sv/wheel_odometer_speedometer.sv
sim/testbench.sv
